@@ sv/pcicfg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_pkg
// Shared constants, codes and controller/datapath command type for the
// emulated type-0 configuration space table.
// ----------------------------------------------------------------------------
package pcicfg_pkg;

	localparam int MAX_DEVICES = 8;
	localparam int CNT_W = $clog2(MAX_DEVICES + 1);
	localparam int IDX_W = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;

	localparam logic [15:0] VENDOR_CODE   = 16'h1AF4;
	localparam logic [15:0] PORT_RESET    = 16'hC000;
	localparam logic [31:0] MEMORY_RESET  = 32'hFEB0_0000;
	localparam logic [15:0] PORT_STRIDE   = 16'd64;
	localparam logic [31:0] MEMORY_STRIDE = 32'd4096;
	localparam logic [7:0]  COMMAND_RESET = 8'h07;
	localparam logic [7:0]  STATUS_LOW    = 8'h10;
	localparam logic [7:0]  INT_PIN       = 8'h01;
	localparam logic [31:0] ALL_ONES      = 32'hFFFF_FFFF;
	localparam logic [31:0] BAR_PROBE     = 32'hFFFF_FFC1;
	localparam logic [8:0]  HEADER_BYTES  = 9'd256;

	// action codes
	localparam logic [1:0] ACT_REGISTER = 2'd0;
	localparam logic [1:0] ACT_READ     = 2'd1;
	localparam logic [1:0] ACT_WRITE    = 2'd2;

	// status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_NODEV = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_FULL  = 2'd3;

	typedef struct packed {
		logic capture;  // latch the incoming transaction
		logic execute;  // run it against the table, load result registers
	} dp_cmd_t;

endpackage : pcicfg_pkg
`default_nettype wire

@@ sv/pci_config_space_endpoint_table_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pci_config_space_endpoint_table_core
// Emulated bus-0 PCI configuration space for up to MAX_DEVICES type-0
// endpoints: registration, config reads and config writes.
// ----------------------------------------------------------------------------
// Usage: a transaction is taken on the rising edge where start is high and
// busy is low. Every transaction has a latch step and then an execute step
// that runs it against the device table (a single table read and/or write
// at the slot's entry). The result appears on read_data/status/assigned_*
// with done high for exactly one cycle, in the cycle busy drops; there is no
// back-pressure, so the receiver must capture it in that cycle. A new
// transaction may be started in the same cycle that done is high, but none
// is accepted while busy is high in the execute step. Registration
// (action 0) allocates slot count+1 with an I/O base from 0xC000 in steps
// of 64 and an MMIO base from 0xFEB00000 in steps of 4096; status 3 reports
// a full table. Reads (action 1) return 1, 2 or 4 little-endian header
// bytes, all ones on failure. Writes (action 2) only affect the command low
// byte (offset 4) and BAR0 (offset 0x10). Table entries hold no reset value;
// only registered slots are reachable.
// ----------------------------------------------------------------------------
module pci_config_space_endpoint_table_core
	import pcicfg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	output logic             done,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  bus_number,
	input  wire logic [7:0]  slot_number,
	input  wire logic [7:0]  function_number,
	input  wire logic [7:0]  byte_offset,
	input  wire logic [2:0]  access_size,
	input  wire logic [31:0] write_value,
	input  wire logic [15:0] device_ident,
	input  wire logic [7:0]  irq_number,
	input  wire logic [7:0]  class_base,
	input  wire logic [7:0]  class_sub,
	output logic [31:0]      read_data,
	output logic [1:0]       status,
	output logic [4:0]       assigned_slot,
	output logic [15:0]      assigned_io_base,
	output logic [31:0]      assigned_mmio_base
);

	// controller -> datapath commands
	dp_cmd_t dp_cmd;

	// sequencer: IDLE accepts, EXEC runs one transaction, done strobes next
	pcicfg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (dp_cmd)
	);

	// datapath: transaction latch, device table, allocators, result regs
	pcicfg_dp u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (dp_cmd),
		.action             (action),
		.bus_number         (bus_number),
		.slot_number        (slot_number),
		.function_number    (function_number),
		.byte_offset        (byte_offset),
		.access_size        (access_size),
		.write_value        (write_value),
		.device_ident       (device_ident),
		.irq_number         (irq_number),
		.class_base         (class_base),
		.class_sub          (class_sub),
		.read_data          (read_data),
		.status             (status),
		.assigned_slot      (assigned_slot),
		.assigned_io_base   (assigned_io_base),
		.assigned_mmio_base (assigned_mmio_base)
	);

endmodule : pci_config_space_endpoint_table_core
`default_nettype wire

@@ sv/pcicfg_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_ctrl
// Two-state sequencer: accept a transaction, execute it, strobe the result.
// ----------------------------------------------------------------------------
module pcicfg_ctrl
	import pcicfg_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	output logic      done,
	output dp_cmd_t   cmd
);

	typedef enum logic {
		S_IDLE,
		S_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy        = (state_q == S_EXEC);
	assign done        = done_q;
	assign cmd.capture = start && !busy;
	assign cmd.execute = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// accepted transaction executes next cycle, result strobes the one after
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> busy && !done)
		else $error("accepted transaction did not enter execute");

	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done && !busy)
		else $error("execute did not produce exactly one result strobe");

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while still executing");

endmodule : pcicfg_ctrl
`default_nettype wire

@@ sv/pcicfg_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// pcicfg_dp
// Transaction registers, per-device header table, base allocators and
// result registers.
// ----------------------------------------------------------------------------
module pcicfg_dp
	import pcicfg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire dp_cmd_t     cmd,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  bus_number,
	input  wire logic [7:0]  slot_number,
	input  wire logic [7:0]  function_number,
	input  wire logic [7:0]  byte_offset,
	input  wire logic [2:0]  access_size,
	input  wire logic [31:0] write_value,
	input  wire logic [15:0] device_ident,
	input  wire logic [7:0]  irq_number,
	input  wire logic [7:0]  class_base,
	input  wire logic [7:0]  class_sub,
	output logic [31:0]      read_data,
	output logic [1:0]       status,
	output logic [4:0]       assigned_slot,
	output logic [15:0]      assigned_io_base,
	output logic [31:0]      assigned_mmio_base
);

	localparam logic [7:0] OFF_VID_LO  = 8'h00;
	localparam logic [7:0] OFF_VID_HI  = 8'h01;
	localparam logic [7:0] OFF_DID_LO  = 8'h02;
	localparam logic [7:0] OFF_DID_HI  = 8'h03;
	localparam logic [7:0] OFF_CMD     = 8'h04;
	localparam logic [7:0] OFF_STS     = 8'h06;
	localparam logic [7:0] OFF_SUBCLS  = 8'h0A;
	localparam logic [7:0] OFF_BASECLS = 8'h0B;
	localparam logic [7:0] OFF_BAR0_0  = 8'h10;
	localparam logic [7:0] OFF_BAR0_1  = 8'h11;
	localparam logic [7:0] OFF_BAR0_2  = 8'h12;
	localparam logic [7:0] OFF_BAR0_3  = 8'h13;
	localparam logic [7:0] OFF_BAR1_0  = 8'h14;
	localparam logic [7:0] OFF_BAR1_1  = 8'h15;
	localparam logic [7:0] OFF_BAR1_2  = 8'h16;
	localparam logic [7:0] OFF_BAR1_3  = 8'h17;
	localparam logic [7:0] OFF_SVID_LO = 8'h2C;
	localparam logic [7:0] OFF_SVID_HI = 8'h2D;
	localparam logic [7:0] OFF_SID_LO  = 8'h2E;
	localparam logic [7:0] OFF_SID_HI  = 8'h2F;
	localparam logic [7:0] OFF_IRQ     = 8'h3C;
	localparam logic [7:0] OFF_PIN     = 8'h3D;

	// latched transaction
	logic [1:0]  action_q;
	logic [7:0]  bus_q, slot_q, func_q, off_q;
	logic [2:0]  size_q;
	logic [31:0] wval_q;
	logic [15:0] ident_q;
	logic [7:0]  irq_q, cbase_q, csub_q;

	// allocator state
	logic [CNT_W-1:0] dev_total_q;
	logic [15:0]      port_base_q;
	logic [31:0]      mem_base_q;

	// per-device table
	logic [15:0] dev_ident_q   [MAX_DEVICES];
	logic [7:0]  dev_cbase_q   [MAX_DEVICES];
	logic [7:0]  dev_csub_q    [MAX_DEVICES];
	logic [7:0]  dev_irq_q     [MAX_DEVICES];
	logic [7:0]  dev_cmd_q     [MAX_DEVICES];
	logic [31:0] dev_bar0_q    [MAX_DEVICES];
	logic [31:0] dev_bar1_q    [MAX_DEVICES];

	// result registers
	logic [31:0] rdata_q;
	logic [1:0]  status_q;
	logic [4:0]  aslot_q;
	logic [15:0] aio_q;
	logic [31:0] ammio_q;

	function automatic logic [7:0] hdr_byte(
		input logic [7:0]  off,
		input logic [15:0] ident,
		input logic [7:0]  cmdlo,
		input logic [7:0]  csub,
		input logic [7:0]  cbase,
		input logic [31:0] bar0,
		input logic [31:0] bar1,
		input logic [7:0]  irq
	);
		logic [7:0] b;
		case (off)
			OFF_VID_LO:  b = VENDOR_CODE[7:0];
			OFF_VID_HI:  b = VENDOR_CODE[15:8];
			OFF_DID_LO:  b = ident[7:0];
			OFF_DID_HI:  b = ident[15:8];
			OFF_CMD:     b = cmdlo;
			OFF_STS:     b = STATUS_LOW;
			OFF_SUBCLS:  b = csub;
			OFF_BASECLS: b = cbase;
			OFF_BAR0_0:  b = bar0[7:0];
			OFF_BAR0_1:  b = bar0[15:8];
			OFF_BAR0_2:  b = bar0[23:16];
			OFF_BAR0_3:  b = bar0[31:24];
			OFF_BAR1_0:  b = bar1[7:0];
			OFF_BAR1_1:  b = bar1[15:8];
			OFF_BAR1_2:  b = bar1[23:16];
			OFF_BAR1_3:  b = bar1[31:24];
			OFF_SVID_LO: b = VENDOR_CODE[7:0];
			OFF_SVID_HI: b = VENDOR_CODE[15:8];
			OFF_SID_LO:  b = ident[7:0];
			OFF_SID_HI:  b = ident[15:8];
			OFF_IRQ:     b = irq;
			OFF_PIN:     b = INT_PIN;
			default:     b = 8'h00;
		endcase
		return b;
	endfunction

	// address decode
	logic [7:0]       slot_m1;
	logic [IDX_W-1:0] rd_idx, wr_idx;
	logic             present, past, size_ok, full;
	logic [CNT_W-1:0] total_inc;
	logic [7:0]       rb [4];
	logic [31:0]      rd_word;

	assign slot_m1   = slot_q - 8'd1;
	assign rd_idx    = slot_m1[IDX_W-1:0];
	assign wr_idx    = dev_total_q[IDX_W-1:0];
	assign total_inc = dev_total_q + CNT_W'(1);
	assign full      = (dev_total_q >= CNT_W'(MAX_DEVICES));
	assign present   = (bus_q == 8'd0) && (func_q == 8'd0) && (slot_q != 8'd0)
	                   && (slot_q <= 8'(dev_total_q));
	assign past      = ({1'b0, off_q} + {6'd0, size_q}) > HEADER_BYTES;
	assign size_ok   = (size_q == 3'd1) || (size_q == 3'd2) || (size_q == 3'd4);

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			rb[k] = hdr_byte(off_q + 8'(k), dev_ident_q[rd_idx], dev_cmd_q[rd_idx],
				dev_csub_q[rd_idx], dev_cbase_q[rd_idx], dev_bar0_q[rd_idx],
				dev_bar1_q[rd_idx], dev_irq_q[rd_idx]);
		end
		case (size_q)
			3'd1:    rd_word = {24'd0, rb[0]};
			3'd2:    rd_word = {16'd0, rb[1], rb[0]};
			default: rd_word = {rb[3], rb[2], rb[1], rb[0]};
		endcase
	end

	// transaction capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= action;
			bus_q    <= bus_number;
			slot_q   <= slot_number;
			func_q   <= function_number;
			off_q    <= byte_offset;
			size_q   <= access_size;
			wval_q   <= write_value;
			ident_q  <= device_ident;
			irq_q    <= irq_number;
			cbase_q  <= class_base;
			csub_q   <= class_sub;
		end
	end

	// allocator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_total_q <= '0;
			port_base_q <= PORT_RESET;
			mem_base_q  <= MEMORY_RESET;
		end else if (cmd.execute && action_q == ACT_REGISTER && !full) begin
			dev_total_q <= total_inc;
			port_base_q <= port_base_q + PORT_STRIDE;
			mem_base_q  <= mem_base_q + MEMORY_STRIDE;
		end
	end

	// table and results
	always_ff @(posedge clk) begin
		if (cmd.execute) begin
			rdata_q  <= 32'd0;
			status_q <= ST_DONE;
			aslot_q  <= 5'd0;
			aio_q    <= 16'd0;
			ammio_q  <= 32'd0;
			case (action_q)
				ACT_REGISTER: begin
					if (full) begin
						status_q <= ST_FULL;
					end else begin
						aslot_q             <= 5'(total_inc);
						aio_q               <= port_base_q;
						ammio_q             <= mem_base_q;
						dev_ident_q[wr_idx] <= ident_q;
						dev_irq_q[wr_idx]   <= irq_q;
						dev_cbase_q[wr_idx] <= cbase_q;
						dev_csub_q[wr_idx]  <= csub_q;
						dev_cmd_q[wr_idx]   <= COMMAND_RESET;
						dev_bar0_q[wr_idx]  <= {16'd0, port_base_q} | 32'd1;
						dev_bar1_q[wr_idx]  <= mem_base_q;
					end
				end
				ACT_READ: begin
					if (!present) begin
						rdata_q  <= ALL_ONES;
						status_q <= ST_NODEV;
					end else if (past || !size_ok) begin
						rdata_q  <= ALL_ONES;
						status_q <= ST_RANGE;
					end else begin
						rdata_q <= rd_word;
					end
				end
				ACT_WRITE: begin
					if (!present) begin
						status_q <= ST_NODEV;
					end else if (past) begin
						status_q <= ST_RANGE;
					end else if (off_q == OFF_CMD) begin
						dev_cmd_q[rd_idx] <= wval_q[7:0];
					end else if (off_q == OFF_BAR0_0) begin
						if (wval_q == ALL_ONES) begin
							dev_bar0_q[rd_idx] <= BAR_PROBE;
						end else begin
							dev_bar0_q[rd_idx] <= {wval_q[31:2], 2'b01};
						end
					end
				end
				default: begin
					status_q <= ST_RANGE;
				end
			endcase
		end
	end

	assign read_data          = rdata_q;
	assign status             = status_q;
	assign assigned_slot      = aslot_q;
	assign assigned_io_base   = aio_q;
	assign assigned_mmio_base = ammio_q;

endmodule : pcicfg_dp
`default_nettype wire
